[rtl/crt_merge_two_congruences_defines.svh]
// assertion macros for the two-congruence merge block
`ifndef CRT_MERGE_TWO_CONGRUENCES_DEFINES_SVH
`define CRT_MERGE_TWO_CONGRUENCES_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CRT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CRT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/crt_pkg.sv]
// ----------------------------------------------------------------------------
// crt_pkg
// shared constants, status codes, micro-op codes and control structs
// ----------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

   localparam int CRT_DATA_WIDTH = 64;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_MOD  = 2'd1;
   localparam logic [1:0] ST_NO_SOL   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [4:0] {
      OP_LOAD,
      OP_CHK_MOD,
      OP_RED_A,
      OP_RED_B,
      OP_E_INIT,
      OP_E_TEST,
      OP_E_DIV,
      OP_E_MUL,
      OP_D_CHK,
      OP_T_SOL,
      OP_AG,
      OP_LCM,
      OP_T_OVF,
      OP_N,
      OP_K,
      OP_INV,
      OP_MM,
      OP_INC,
      OP_RES,
      OP_FAIL_MOD,
      OP_FAIL_SOL,
      OP_FAIL_OVF
   } crt_op_type;

   typedef struct packed {
      crt_op_type op;
      logic       start;
      logic       wb;
   } crt_cmd_type;

   typedef struct packed {
      logic done;
      logic mod_bad;
      logic y_zero;
      logic no_sol;
      logic ovf;
   } crt_stat_type;

endpackage

`default_nettype wire

[rtl/crt_merge_two_congruences.sv]
// W = DATA_WIDTH; E = euclid rounds (E <= ~1.44W)
// one item at a time, next request the cycle after the response
// a euclid round is a test, a division and a multiply
// a rejected modulus runs no serial unit: it goes from the modulus check to the failure response
// reset is synchronous and returns the sequencer to idle; nothing is kept between items
// ----------------------------------------------------------------------------
// crt_merge_two_congruences
// merges two congruences into one modulo the lcm, with status on failure
// ----------------------------------------------------------------------------
`default_nettype none

module crt_merge_two_congruences #(
   parameter int DATA_WIDTH = crt_pkg::CRT_DATA_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beat
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_rem_a,
   input  wire logic [63:0] req_mod_a,
   input  wire logic [63:0] req_rem_b,
   input  wire logic [63:0] req_mod_b,
   // response beat
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [62:0]      rsp_merged_rem,
   output logic [62:0]      rsp_merged_mod
);
   import crt_pkg::*;

   crt_cmd_type  cmd;
   crt_stat_type stat;

   // sequencer: load, modulus check, reductions, euclid loop, checks, combine
   crt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: the response fields come straight from its result registers,
   // which hold still while the response beat waits
   crt_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .rem_a      (req_rem_a),
      .mod_a      (req_mod_a),
      .rem_b      (req_rem_b),
      .mod_b      (req_mod_b),
      .status     (rsp_status),
      .merged_rem (rsp_merged_rem),
      .merged_mod (rsp_merged_mod)
   );

endmodule

`default_nettype wire

[rtl/crt_div.sv]
// ----------------------------------------------------------------------------
// crt_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module crt_div #(
   parameter int DATA_WIDTH = crt_pkg::CRT_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_WIDTH-1:0] num,
   input  wire logic [DATA_WIDTH-1:0] den,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      quo,
   output logic [DATA_WIDTH-1:0]      rem
);
   import crt_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    rem_sh, diff;
   logic          qbit;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      qbit    = ~diff[W];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[W-1:0] : rem_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

[rtl/crt_mul.sv]
// ----------------------------------------------------------------------------
// crt_mul
// serial shift-and-add multiplier, msb first, wrapping product and range flag
// ----------------------------------------------------------------------------
`default_nettype none

module crt_mul #(
   parameter int DATA_WIDTH = crt_pkg::CRT_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_WIDTH-1:0] a,
   input  wire logic [DATA_WIDTH-1:0] b,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      prod,
   output logic                       ovf
);
   import crt_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   logic [W-1:0]  a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    sum;

   always_comb begin
      sum     = {1'b0, acc_ff[W-2:0], 1'b0} + (b_ff[W-1] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // a set top bit before doubling, or a carry, means the true product is too big
         ovf_in = ovf_ff | acc_ff[W-1] | sum[W];
         acc_in = sum[W-1:0];
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
   // product at or above the signed maximum plus one
   assign ovf  = ovf_ff | acc_ff[W-1];

endmodule

`default_nettype wire

[rtl/crt_mulmod.sv]
// ----------------------------------------------------------------------------
// crt_mulmod
// modular product by double-and-add, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module crt_mulmod #(
   parameter int DATA_WIDTH = crt_pkg::CRT_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_WIDTH-1:0] a,
   input  wire logic [DATA_WIDTH-1:0] b,
   input  wire logic [DATA_WIDTH-1:0] m,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      res
);
   import crt_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] md);
      logic [W-1:0] d;
      d = md - y;
      return (x >= d) ? (x - d) : (x + y);
   endfunction

   logic [W-1:0]  a_ff, a_in, b_ff, b_in, m_ff, m_in, acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         m_in    = m;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = add_mod(acc_ff, a_ff, m_ff);
         end
         a_in   = add_mod(a_ff, a_ff, m_ff);
         b_in   = {1'b0, b_ff[W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign res  = acc_ff;

endmodule

`default_nettype wire

[rtl/crt_dp.sv]
// ----------------------------------------------------------------------------
// crt_dp
// operand registers, serial units (divider and multiplier shared) and write-back per micro-op
// ----------------------------------------------------------------------------
`default_nettype none

module crt_dp #(
   parameter int DATA_WIDTH = crt_pkg::CRT_DATA_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crt_pkg::crt_cmd_type cmd,
   output crt_pkg::crt_stat_type     stat,
   input  wire logic [63:0]          rem_a,
   input  wire logic [63:0]          mod_a,
   input  wire logic [63:0]          rem_b,
   input  wire logic [63:0]          mod_b,
   output logic [1:0]                status,
   output logic [62:0]               merged_rem,
   output logic [62:0]               merged_mod
);
   import crt_pkg::*;

   localparam int W = DATA_WIDTH;

   function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] md);
      logic [W-1:0] d;
      d = md - y;
      return (x >= d) ? (x - d) : (x + y);
   endfunction

   logic [W-1:0] ra_ff, ra_in, ma_ff, ma_in, rb_ff, rb_in, mb_ff, mb_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, s0_ff, s0_in, s1_ff, s1_in;
   logic [W-1:0] tq_ff, tq_in, tr_ff, tr_in, dq_ff, dq_in, n_ff, n_in;
   logic [W-1:0] nd_ff, nd_in, inv_ff, inv_in, mult_ff, mult_in, inc_ff, inc_in;
   logic [W-1:0] lcm_ff, lcm_in, res_ff, res_in;
   logic [1:0]   status_ff, status_in;
   logic         no_sol_ff, no_sol_in, ovf_ff, ovf_in;

   logic [W-1:0] div_num, div_den, div_quo, div_rem;
   logic [W-1:0] mul_a, mul_b, mul_prod, mm_res;
   logic         div_start, mul_start, mm_start;
   logic         div_done, mul_done, mm_done, mul_ovf;
   logic         dneg;
   logic [W-1:0] dmag;

   assign dneg = rb_ff < ra_ff;
   assign dmag = dneg ? (ra_ff - rb_ff) : (rb_ff - ra_ff);

   // operand selection for the shared units
   always_comb begin
      div_num = x_ff;
      div_den = y_ff;
      mul_a   = tq_ff;
      mul_b   = s1_ff;
      case (cmd.op)
         OP_RED_A: begin
            div_num = ra_ff[W-1] ? (-ra_ff) : ra_ff;
            div_den = ma_ff;
         end
         OP_RED_B: begin
            div_num = rb_ff[W-1] ? (-rb_ff) : rb_ff;
            div_den = mb_ff;
         end
         OP_D_CHK: begin
            div_num = dmag;
            div_den = x_ff;
         end
         OP_AG: begin
            div_num = ma_ff;
            div_den = x_ff;
         end
         OP_N: begin
            div_num = mb_ff;
            div_den = x_ff;
         end
         OP_K: begin
            div_num = dq_ff;
            div_den = n_ff;
         end
         OP_INV: begin
            div_num = s0_ff[W-1] ? (-s0_ff) : s0_ff;
            div_den = n_ff;
         end
         OP_LCM: begin
            mul_a = tq_ff;
            mul_b = mb_ff;
         end
         OP_INC: begin
            mul_a = ma_ff;
            mul_b = mult_ff;
         end
         default: begin
         end
      endcase
   end

   assign div_start = cmd.start && (cmd.op inside {OP_RED_A, OP_RED_B, OP_E_DIV, OP_D_CHK,
                                                   OP_AG, OP_N, OP_K, OP_INV});
   assign mul_start = cmd.start && (cmd.op inside {OP_E_MUL, OP_LCM, OP_INC});
   assign mm_start  = cmd.start && (cmd.op == OP_MM);

   crt_div #(.DATA_WIDTH(W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   crt_mul #(.DATA_WIDTH(W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod),
      .ovf   (mul_ovf)
   );

   crt_mulmod #(.DATA_WIDTH(W)) u_mm (
      .clock (clock),
      .reset (reset),
      .start (mm_start),
      .a     (nd_ff),
      .b     (inv_ff),
      .m     (n_ff),
      .done  (mm_done),
      .res   (mm_res)
   );

   // write-back
   always_comb begin
      ra_in     = ra_ff;
      ma_in     = ma_ff;
      rb_in     = rb_ff;
      mb_in     = mb_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      s0_in     = s0_ff;
      s1_in     = s1_ff;
      tq_in     = tq_ff;
      tr_in     = tr_ff;
      dq_in     = dq_ff;
      n_in      = n_ff;
      nd_in     = nd_ff;
      inv_in    = inv_ff;
      mult_in   = mult_ff;
      inc_in    = inc_ff;
      lcm_in    = lcm_ff;
      res_in    = res_ff;
      status_in = status_ff;
      no_sol_in = no_sol_ff;
      ovf_in    = ovf_ff;
      if (cmd.wb) begin
         case (cmd.op)
            OP_LOAD: begin
               ra_in = rem_a[W-1:0];
               ma_in = mod_a[W-1:0];
               rb_in = rem_b[W-1:0];
               mb_in = mod_b[W-1:0];
            end
            OP_RED_A: begin
               if (ra_ff[W-1]) begin
                  ra_in = (div_rem != '0) ? (ma_ff - div_rem) : '0;
               end else begin
                  ra_in = div_rem;
               end
            end
            OP_RED_B: begin
               if (rb_ff[W-1]) begin
                  rb_in = (div_rem != '0) ? (mb_ff - div_rem) : '0;
               end else begin
                  rb_in = div_rem;
               end
            end
            OP_E_INIT: begin
               x_in  = ma_ff;
               y_in  = mb_ff;
               s0_in = {{(W-1){1'b0}}, 1'b1};
               s1_in = '0;
            end
            OP_E_DIV: begin
               tq_in = div_quo;
               tr_in = div_rem;
            end
            OP_E_MUL: begin
               x_in  = y_ff;
               y_in  = tr_ff;
               s0_in = s1_ff;
               s1_in = s0_ff - mul_prod;
            end
            OP_D_CHK: begin
               dq_in     = div_quo;
               no_sol_in = div_rem != '0;
            end
            OP_AG: begin
               tq_in = div_quo;
            end
            OP_LCM: begin
               lcm_in = mul_prod;
               ovf_in = mul_ovf;
            end
            OP_N: begin
               n_in = div_quo;
            end
            OP_K: begin
               if (dneg) begin
                  nd_in = (div_rem != '0) ? (n_ff - div_rem) : '0;
               end else begin
                  nd_in = div_rem;
               end
            end
            OP_INV: begin
               if (s0_ff[W-1]) begin
                  inv_in = (div_rem != '0) ? (n_ff - div_rem) : '0;
               end else begin
                  inv_in = div_rem;
               end
            end
            OP_MM: begin
               mult_in = mm_res;
            end
            OP_INC: begin
               inc_in = mul_prod;
            end
            OP_RES: begin
               res_in    = add_mod(ra_ff, inc_ff, lcm_ff);
               status_in = ST_OK;
            end
            OP_FAIL_MOD: begin
               res_in    = '0;
               lcm_in    = '0;
               status_in = ST_BAD_MOD;
            end
            OP_FAIL_SOL: begin
               res_in    = '0;
               lcm_in    = '0;
               status_in = ST_NO_SOL;
            end
            OP_FAIL_OVF: begin
               res_in    = '0;
               lcm_in    = '0;
               status_in = ST_OVERFLOW;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ra_ff     <= ra_in;
      ma_ff     <= ma_in;
      rb_ff     <= rb_in;
      mb_ff     <= mb_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      tq_ff     <= tq_in;
      tr_ff     <= tr_in;
      dq_ff     <= dq_in;
      n_ff      <= n_in;
      nd_ff     <= nd_in;
      inv_ff    <= inv_in;
      mult_ff   <= mult_in;
      inc_ff    <= inc_in;
      lcm_ff    <= lcm_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      no_sol_ff <= no_sol_in;
      ovf_ff    <= ovf_in;
   end

   assign stat.done    = div_done | mul_done | mm_done;
   assign stat.mod_bad = (ma_ff == '0) | ma_ff[W-1] | (mb_ff == '0) | mb_ff[W-1];
   assign stat.y_zero  = y_ff == '0;
   assign stat.no_sol  = no_sol_ff;
   assign stat.ovf     = ovf_ff;

   assign status     = status_ff;
   assign merged_rem = 63'(res_ff[W-2:0]);
   assign merged_mod = 63'(lcm_ff[W-2:0]);

endmodule

`default_nettype wire

[rtl/crt_ctrl.sv]
// ----------------------------------------------------------------------------
// crt_ctrl
// micro-op sequencer: issues each step, waits on the units, branches on flags
// ----------------------------------------------------------------------------
`default_nettype none

module crt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output crt_pkg::crt_cmd_type       cmd,
   input  wire crt_pkg::crt_stat_type stat
);
   import crt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_type;

   state_type  state_ff;
   crt_op_type op_ff;

   function automatic logic uses_unit(input crt_op_type op);
      case (op)
         OP_RED_A, OP_RED_B, OP_E_DIV, OP_E_MUL, OP_D_CHK, OP_AG,
         OP_LCM, OP_N, OP_K, OP_INV, OP_MM, OP_INC: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_last(input crt_op_type op);
      case (op)
         OP_RES, OP_FAIL_MOD, OP_FAIL_SOL, OP_FAIL_OVF: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic crt_op_type next_op(input crt_op_type op, input crt_stat_type st);
      case (op)
         OP_CHK_MOD: return st.mod_bad ? OP_FAIL_MOD : OP_RED_A;
         OP_RED_A:   return OP_RED_B;
         OP_RED_B:   return OP_E_INIT;
         OP_E_INIT:  return OP_E_TEST;
         OP_E_TEST:  return st.y_zero ? OP_D_CHK : OP_E_DIV;
         OP_E_DIV:   return OP_E_MUL;
         OP_E_MUL:   return OP_E_TEST;
         OP_D_CHK:   return OP_T_SOL;
         OP_T_SOL:   return st.no_sol ? OP_FAIL_SOL : OP_AG;
         OP_AG:      return OP_LCM;
         OP_LCM:     return OP_T_OVF;
         OP_T_OVF:   return st.ovf ? OP_FAIL_OVF : OP_N;
         OP_N:       return OP_K;
         OP_K:       return OP_INV;
         OP_INV:     return OP_MM;
         OP_MM:      return OP_INC;
         OP_INC:     return OP_RES;
         default:    return OP_CHK_MOD;
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_CHK_MOD;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= OP_CHK_MOD;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: begin
               if (uses_unit(op_ff)) begin
                  state_ff <= S_WAIT;
               end else if (is_last(op_ff)) begin
                  state_ff <= S_OUT;
               end else begin
                  op_ff <= next_op(op_ff, stat);
               end
            end
            S_WAIT: begin
               if (stat.done) begin
                  op_ff    <= next_op(op_ff, stat);
                  state_ff <= S_ISSUE;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd.op    = (state_ff == S_IDLE) ? OP_LOAD : op_ff;
      cmd.start = (state_ff == S_ISSUE) && uses_unit(op_ff);
      cmd.wb    = ((state_ff == S_IDLE) && req_valid) ||
                  ((state_ff == S_ISSUE) && !uses_unit(op_ff)) ||
                  ((state_ff == S_WAIT) && stat.done);
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

endmodule

`default_nettype wire

[rtl/crt_checker.sv]
// ----------------------------------------------------------------------------
// crt_checker
// port-level checks on the merge block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "crt_merge_two_congruences_defines.svh"

module crt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [62:0] rsp_merged_rem,
   input wire logic [62:0] rsp_merged_mod
);
   import crt_pkg::*;

   `CRT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_merged_rem) && $stable(rsp_merged_mod), "stalled response changed")
   `CRT_ASSERT_NXT(a_no_instant_rsp, req_valid && !req_stall, !rsp_valid, "response right after request beat")
   `CRT_ASSERT_IMP(a_busy_while_rsp, rsp_valid, req_stall, "request taken while response pending")
   `CRT_ASSERT_IMP(a_err_zero, rsp_valid && (rsp_status != ST_OK), (rsp_merged_rem == 63'd0) && (rsp_merged_mod == 63'd0), "error response not zeroed")
   `CRT_ASSERT_IMP(a_rem_range, rsp_valid && (rsp_status == ST_OK), rsp_merged_rem < rsp_merged_mod, "merged remainder out of range")

endmodule

bind crt_merge_two_congruences crt_checker u_crt_checker (.*);

`default_nettype wire
